// ===== design/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared sizes, item codes, the search state type and the structs that pass
// between the search engine and the top level.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 10;
    localparam int POS_W  = 10;
    localparam int MODE_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_EXACT = 2'd1,
        MODE_LOWER = 2'd2,
        MODE_NONE  = 2'd3
    } stbs_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_RESULT
    } stbs_state_t;

    typedef struct packed {
        logic                     lower;
        logic signed [DATA_W-1:0] key;
    } stbs_query_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } stbs_result_t;

endpackage

// ===== design/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int RAM_WIDTH = 32,
    parameter int RAM_DEPTH = 1024,
    localparam int RAM_ADDR_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [RAM_ADDR_W-1:0]        waddr,
    input  logic [RAM_WIDTH-1:0]         wdata,
    input  logic                         re,
    input  logic [RAM_ADDR_W-1:0]        raddr,
    output logic [RAM_WIDTH-1:0]         rdata
);

    logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/stbs_search.sv =====
// ----------------------------------------------------------------------------
// Sorted table search engine
// Runs the halving search over the table memory, one probe per cycle, with
// both possible next probe addresses prepared ahead of the compare.
// ----------------------------------------------------------------------------
module stbs_search
    import stbs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  stbs_query_t       query,
    input  logic [CNT_W-1:0]  used_count,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [DATA_W-1:0] rd_data,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output stbs_result_t      res
);

    stbs_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic [ADDR_W-1:0] best_reg, best_next;
    logic              found_reg, found_next;
    stbs_query_t       query_reg, query_next;

    logic [CNT_W-1:0]  mid_ext;
    logic [CNT_W-1:0]  mid_inc;
    logic [SUM_W-1:0]  sum_0;
    logic [SUM_W-1:0]  sum_r;
    logic [SUM_W-1:0]  sum_l;
    logic              ge;
    logic              eq;
    logic              cont_r;
    logic              cont_l;
    logic              finish;

    assign mid_ext = CNT_W'(mid_reg);
    assign mid_inc = mid_ext + CNT_W'(1);
    assign sum_0   = SUM_W'(used_count) - SUM_W'(1);
    assign sum_r   = SUM_W'(mid_ext) + SUM_W'(hi_reg);
    assign sum_l   = SUM_W'(lo_reg) + SUM_W'(mid_ext) - SUM_W'(1);
    assign ge      = $signed(rd_data) >= query_reg.key;
    assign eq      = $signed(rd_data) == query_reg.key;
    assign cont_r  = mid_inc < hi_reg;
    assign cont_l  = lo_reg < mid_ext;
    assign finish  = (!query_reg.lower && eq) || (ge ? !cont_l : !cont_r);
    assign idle    = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        query_reg <= query_next;
    end

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        query_next   = query_reg;
        rd_en        = 1'b0;
        rd_addr      = mid_reg;
        res_valid    = 1'b0;
        res.found    = found_reg;
        res.position = POS_W'(best_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    lo_next    = '0;
                    hi_next    = used_count;
                    query_next = query;
                    found_next = 1'b0;
                    best_next  = '0;
                    if (used_count != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(sum_0[SUM_W-1:1]);
                        state_next = ST_PROBE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_PROBE: begin
                if ((query_reg.lower && ge) || (!query_reg.lower && eq)) begin
                    found_next = 1'b1;
                    best_next  = mid_reg;
                end
                if (ge) begin
                    hi_next = mid_ext;
                end else begin
                    lo_next = mid_inc;
                end
                if (finish) begin
                    res_valid    = 1'b1;
                    res.found    = found_next;
                    res.position = POS_W'(best_next);
                    state_next   = res_ready ? ST_IDLE : ST_RESULT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ge ? ADDR_W'(sum_l[SUM_W-1:1]) : ADDR_W'(sum_r[SUM_W-1:1]);
                end
            end
            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        mid_next = rd_en ? rd_addr : mid_reg;
    end

    a_window_holds_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PROBE |-> (lo_reg <= mid_ext) && (mid_ext < hi_reg))
        else $error("probe address outside the search window");

    a_window_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PROBE |-> hi_reg <= CNT_W'(DEPTH))
        else $error("search window extends past the table");

    a_exact_no_early_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PROBE && !query_reg.lower |-> !found_reg)
        else $error("exact search kept probing after a match");

endmodule

// ===== design/sorted_table_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search
// Holds a table of signed words in a RAM, takes load and query transfers and
// returns the exact match or the lower-bound index for each query.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  input   | s_valid s_ready s_mode s_entry_index ... | in
//  result  | m_valid m_ready m_found m_position       | out
//  config  | cfg_valid cfg_ready cfg_entry_count      | in
//
// A load gives no result. A query issues the first read when it is accepted
// and then makes one probe per cycle, at most ceil(log2(entry_count + 1))
// probes (11 for a full table), bounded by the single table read port. The
// result then sits in the output register. An empty table answers from the
// result state with no probe. Reset is synchronous and active low and leaves
// the table contents unchanged. A stalled result holds the engine in its
// result state; no new transfer is taken until the output register frees.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top
    import stbs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [MODE_W-1:0]        s_mode,
    input  logic [IDX_W-1:0]         s_entry_index,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_found,
    output logic [POS_W-1:0]         m_position,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_entry_count
);

    logic [CFG_W-1:0]  entry_count_reg;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg;
    logic [POS_W-1:0]  m_position_reg;

    logic              in_xfer;
    logic              ram_we;
    logic              start;
    stbs_query_t       query;
    logic [CNT_W-1:0]  used_count;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              idle;
    logic              res_valid;
    logic              res_ready;
    stbs_result_t      res;

    assign cfg_ready   = 1'b1;
    assign s_ready     = idle;
    assign in_xfer     = s_valid && s_ready;
    assign query.lower = (stbs_mode_t'(s_mode) == MODE_LOWER);
    assign query.key   = s_value;
    assign used_count  = (32'(entry_count_reg) > 32'(DEPTH)) ? CNT_W'(DEPTH)
                                                             : CNT_W'(entry_count_reg);

    always_comb begin
        ram_we = 1'b0;
        start  = 1'b0;
        unique case (stbs_mode_t'(s_mode))
            MODE_LOAD:               ram_we = in_xfer && (32'(s_entry_index) < 32'(DEPTH));
            MODE_EXACT, MODE_LOWER:  start  = in_xfer;
            MODE_NONE:               ;
            default:                 ;
        endcase
    end

    stbs_ram #(
        .RAM_WIDTH (DATA_W),
        .RAM_DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ADDR_W'(s_entry_index)),
        .wdata (s_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    stbs_search u_search (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .query      (query),
        .used_count (used_count),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .idle       (idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready    = !m_valid_reg || m_ready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                entry_count_reg <= cfg_entry_count;
            end
            m_valid_reg <= m_valid_next;
        end
        if (res_valid && res_ready) begin
            m_found_reg    <= res.found;
            m_position_reg <= res.position;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;

    a_no_load_during_search: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && rd_en))
        else $error("table write overlaps a search read");

    a_miss_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> m_position_reg == '0)
        else $error("miss result carries a nonzero position");

endmodule
